// ===== rtl/isr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package isr_pkg;

   // Width of one stored value
   localparam int unsigned DATA_W = 32;

   // Per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic insert;  // place the broadcast value, larger entries move up
      logic shift;   // every cell takes its right neighbor's value, the top cell keeps its own
   } ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/isr_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface isr_req_if;
   logic                        valid;
   logic                        ready;
   logic signed [isr_pkg::DATA_W-1:0] value;
   logic                        last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/isr_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface isr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic signed [isr_pkg::DATA_W-1:0] sorted_value;
   logic                        end_of_set;
   logic                        overflow;

   modport source (output valid, output sorted_value, output end_of_set,
                   output overflow, input ready);
   modport sink   (input valid, input sorted_value, input end_of_set,
                   input overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/isr_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module isr_cell (
   input  wire                               clock,
   input  isr_pkg::ctrl_type                 ctrl,
   input  wire                               occupied,
   input  wire signed [isr_pkg::DATA_W-1:0]  new_value,
   input  wire                               left_gt,
   input  wire signed [isr_pkg::DATA_W-1:0]  left_value,
   input  wire signed [isr_pkg::DATA_W-1:0]  right_value,
   output logic                              gt,
   output logic signed [isr_pkg::DATA_W-1:0] value
);
   import isr_pkg::*;

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;

   // An empty cell counts as +infinity; strict compare keeps equal values in arrival order
   assign gt = !occupied || (new_value < value_ff);

   // Insert: the first greater cell takes the new value, cells above it take the left one
   always_comb begin
      value_in = value_ff;
      if (ctrl.insert && gt) begin
         value_in = left_gt ? left_value : new_value;
      end else if (ctrl.shift) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

// ===== rtl/insertion_sorter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Payload                               | Transfer
// req_if  | in        | value[31:0] signed, last              | valid && ready
// rsp_if  | out       | sorted_value[31:0], end_of_set, overflow | valid && ready
//
// One value is taken per cycle while a set is filling: every cell of the chain
// compares against the broadcast value at once and the shift-up happens in the
// same cycle. After the item marked last the chain shifts toward cell 0, one
// stored value per rsp transfer, one transfer per stored value (at most CAPACITY);
// req_if.ready is low during the drain. Reset (synchronous) empties the store.
// A stall on rsp_if holds the head cell and the drain in place.

module insertion_sorter #(
   parameter int unsigned CAPACITY = 64
) (
   input wire        clock,
   input wire        reset,
   isr_req_if.sink   req_if,
   isr_rsp_if.source rsp_if
);
   import isr_pkg::*;

   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic {
      ST_FILL,
      ST_DRAIN
   } state_type;

   state_type          state_ff;
   logic [CNT_W-1:0]   fill_count_ff;
   logic               dropped_ff;

   logic               full;
   logic               req_xfer;
   logic               rsp_xfer;
   ctrl_type           ctrl;

   logic                     cell_gt    [CAPACITY];
   logic signed [DATA_W-1:0] cell_value [CAPACITY];

   assign full     = (fill_count_ff == CNT_W'(CAPACITY));
   assign req_xfer = req_if.valid && req_if.ready;
   assign rsp_xfer = rsp_if.valid && rsp_if.ready;

   assign ctrl.insert = req_xfer && !full;
   assign ctrl.shift  = rsp_xfer;

   // Chain of cells; cell 0 holds the smallest value and feeds the result port
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                     left_gt;
      logic signed [DATA_W-1:0] left_value;
      logic signed [DATA_W-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_gt    = 1'b0;
         assign left_value = req_if.value;
      end else begin : g_mid
         assign left_gt    = cell_gt[i-1];
         assign left_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_top
         assign right_value = cell_value[i];
      end else begin : g_below
         assign right_value = cell_value[i+1];
      end

      isr_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (CNT_W'(i) < fill_count_ff),
         .new_value   (req_if.value),
         .left_gt     (left_gt),
         .left_value  (left_value),
         .right_value (right_value),
         .gt          (cell_gt[i]),
         .value       (cell_value[i])
      );
   end

   // Fill / drain sequencing, fill count and drop flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_FILL;
         fill_count_ff <= '0;
         dropped_ff    <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_FILL: begin
               if (req_xfer) begin
                  if (full) begin
                     dropped_ff <= 1'b1;
                  end else begin
                     fill_count_ff <= fill_count_ff + CNT_W'(1);
                  end
                  if (req_if.last) begin
                     state_ff <= ST_DRAIN;
                  end
               end
            end
            ST_DRAIN: begin
               if (rsp_xfer) begin
                  fill_count_ff <= fill_count_ff - CNT_W'(1);
                  if (fill_count_ff == CNT_W'(1)) begin
                     state_ff   <= ST_FILL;
                     dropped_ff <= 1'b0;
                  end
               end
            end
            default: begin
               state_ff <= ST_FILL;
            end
         endcase
      end
   end

   assign req_if.ready = (state_ff == ST_FILL);

   // Results come straight from the head cell
   assign rsp_if.valid        = (state_ff == ST_DRAIN);
   assign rsp_if.sorted_value = cell_value[0];
   assign rsp_if.end_of_set   = (fill_count_ff == CNT_W'(1));
   assign rsp_if.overflow     = dropped_ff;

endmodule

`default_nettype wire

// ===== rtl/isr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module isr_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire        req_last,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [31:0] rsp_sorted_value,
   input wire        rsp_end_of_set,
   input wire        rsp_overflow
);

   // No new values are taken while a set is being delivered
   a_no_accept_in_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("req ready while results pending");

   // The item marked last opens the delivery of its set
   a_last_starts_drain: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> rsp_valid)
      else $error("no result after last item");

   // Delivery stops right after the final transfer of a set
   a_end_closes_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_end_of_set |=> !rsp_valid && req_ready)
      else $error("results continue after end of set");

   // Within a set, delivery continues and the overflow flag does not change
   a_set_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_end_of_set |=>
         rsp_valid && (rsp_overflow == $past(rsp_overflow)))
      else $error("set broken off or overflow flag changed");

   // A stalled result holds
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_sorted_value) && $stable(rsp_end_of_set))
      else $error("stalled result changed");

endmodule

bind insertion_sorter isr_checker u_isr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .req_last         (req_if.last),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_sorted_value (rsp_if.sorted_value),
   .rsp_end_of_set   (rsp_if.end_of_set),
   .rsp_overflow     (rsp_if.overflow)
);

`default_nettype wire
